// ===== src/bitmap_frame_allocator_core_assert.svh =====
// Assertion macros for the bitmap frame allocator.
// Used by the top level only; no other dependencies.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== src/bfa_pkg.sv =====
// Shared constants, codes and types for the bitmap frame allocator.
// No dependencies; imported by every module of the block.
package bfa_pkg;

   // Map geometry
   localparam int MAP_CELLS    = 4096;
   localparam int FRAME_BYTES  = 4096;
   localparam int ADDR_W       = 32;
   localparam int FRAME_SHIFT  = $clog2(FRAME_BYTES);
   localparam int CELL_BITS    = 8;
   localparam int BIT_W        = 3;
   localparam int CELL_FIELD_W = ADDR_W - FRAME_SHIFT - BIT_W;

   // Summary: one bit per cell, 64 cells per summary row
   localparam int SUM_BITS   = 64;
   localparam int COL_W      = 6;
   localparam int SUM_ROWS   = (MAP_CELLS + SUM_BITS - 1) / SUM_BITS;
   localparam int ROW_W      = (SUM_ROWS > 1) ? $clog2(SUM_ROWS) : 1;
   localparam int CELL_W     = ROW_W + COL_W;
   localparam int CELL_DEPTH = SUM_ROWS * SUM_BITS;
   localparam int FULL_W     = CELL_W + BIT_W + FRAME_SHIFT;

   // Command codes
   localparam logic [1:0] CMD_FREE  = 2'd0;
   localparam logic [1:0] CMD_USED  = 2'd1;
   localparam logic [1:0] CMD_ALLOC = 2'd2;

   // Status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NONE_FREE = 2'd1;
   localparam logic [1:0] ST_BEYOND    = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [ADDR_W-1:0] byte_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      logic [1:0]        status;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic mark_rd;
      logic top_pick;
      logic sum_pick;
      logic cell_pick;
      logic write_back;
      logic set_beyond;
      logic set_none;
      logic out_load;
   } bfa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic is_mark;
      logic is_alloc;
      logic beyond;
      logic top_empty;
      logic out_free;
   } bfa_stat_type;

endpackage

// ===== src/bfa_dp.sv =====
// Datapath: cell memory, summary memory, top-level summary register,
// request and result registers. Depends on bfa_pkg.
module bfa_dp
   import bfa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bfa_cmd_type     cmd,
   output bfa_stat_type    stat,
   input  req_payload_type req_payload,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   // Storage
   logic [CELL_BITS-1:0] cell_mem [CELL_DEPTH];
   logic [SUM_BITS-1:0]  sum_mem  [SUM_ROWS];

   // Registers
   logic [1:0]           command_ff;
   logic [CELL_W-1:0]    cell_idx_ff, cell_idx_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic                 beyond_ff, beyond_in;
   logic [CELL_BITS-1:0] cell_rd_ff;
   logic [SUM_BITS-1:0]  sum_rd_ff;
   logic [SUM_ROWS-1:0]  top_ff;
   logic [CELL_W-1:0]    clr_cnt_ff;
   logic [ADDR_W-1:0]    res_frame_ff;
   logic [1:0]           res_status_ff;
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_data_ff;

   // Combinational
   logic [CELL_FIELD_W-1:0] cell_field;
   logic [ROW_W-1:0]        cur_row, top_row;
   logic [COL_W-1:0]        cur_col, sum_col;
   logic [BIT_W-1:0]        cell_first;
   logic [CELL_BITS-1:0]    bit_mask, new_cell;
   logic [SUM_BITS-1:0]     new_sum;
   logic [FULL_W-1:0]       full_addr;
   logic                    cell_we, cell_re, sum_we, sum_re;
   logic [CELL_W-1:0]       cell_wa, cell_ra;
   logic [CELL_BITS-1:0]    cell_wd;
   logic [ROW_W-1:0]        sum_wa, sum_ra;
   logic [SUM_BITS-1:0]     sum_wd;

   // Request decode: cell index, bit in cell, range check
   assign cell_field = req_payload.byte_address[ADDR_W-1 -: CELL_FIELD_W];
   assign beyond_in  = ADDR_W'(cell_field) >= ADDR_W'(MAP_CELLS);
   assign bit_in     = req_payload.byte_address[FRAME_SHIFT +: BIT_W];
   assign cur_row    = cell_idx_ff[CELL_W-1:COL_W];
   assign cur_col    = cell_idx_ff[COL_W-1:0];

   // Lowest set bit of the top summary, of a summary row and of a cell
   always_comb begin
      top_row = '0;
      for (int i = SUM_ROWS - 1; i >= 0; i--) begin
         if (top_ff[i]) top_row = ROW_W'(i);
      end
   end

   always_comb begin
      sum_col = '0;
      for (int i = SUM_BITS - 1; i >= 0; i--) begin
         if (sum_rd_ff[i]) sum_col = COL_W'(i);
      end
   end

   always_comb begin
      cell_first = '0;
      for (int i = CELL_BITS - 1; i >= 0; i--) begin
         if (cell_rd_ff[i]) cell_first = BIT_W'(i);
      end
   end

   // Read-modify-write values
   assign bit_mask = CELL_BITS'(1) << bit_ff;
   assign new_cell = (command_ff == CMD_FREE) ? (cell_rd_ff | bit_mask)
                                              : (cell_rd_ff & ~bit_mask);
   always_comb begin
      new_sum          = sum_rd_ff;
      new_sum[cur_col] = |new_cell;
   end
   assign full_addr = {cell_idx_ff, bit_ff, {FRAME_SHIFT{1'b0}}};

   // Memory port steering
   assign cell_we = cmd.clr_step | cmd.write_back;
   assign cell_wa = cmd.clr_step ? clr_cnt_ff : cell_idx_ff;
   assign cell_wd = cmd.clr_step ? '0 : new_cell;
   assign cell_re = cmd.mark_rd | cmd.sum_pick;
   assign cell_ra = cmd.sum_pick ? {cur_row, sum_col} : cell_idx_ff;

   assign sum_we = (cmd.clr_step & (clr_cnt_ff < CELL_W'(SUM_ROWS))) | cmd.write_back;
   assign sum_wa = cmd.clr_step ? clr_cnt_ff[ROW_W-1:0] : cur_row;
   assign sum_wd = cmd.clr_step ? '0 : new_sum;
   assign sum_re = cmd.mark_rd | cmd.top_pick;
   assign sum_ra = cmd.top_pick ? top_row : cur_row;

   // Cell memory, registered read
   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_wa] <= cell_wd;
      if (cell_re) cell_rd_ff <= cell_mem[cell_ra];
   end

   // Summary memory, registered read
   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      if (sum_re) sum_rd_ff <= sum_mem[sum_ra];
   end

   // Working index of the current transaction
   always_comb begin
      cell_idx_in = cell_idx_ff;
      if (cmd.accept)    cell_idx_in = CELL_W'(cell_field);
      if (cmd.top_pick)  cell_idx_in = {top_row, COL_W'(0)};
      if (cmd.sum_pick)  cell_idx_in = {cur_row, sum_col};
   end

   // Request, working and result registers (payload, no reset)
   always_ff @(posedge clock) begin
      cell_idx_ff <= cell_idx_in;
      if (cmd.accept) begin
         command_ff    <= req_payload.command;
         bit_ff        <= bit_in;
         beyond_ff     <= beyond_in;
         res_frame_ff  <= '0;
         res_status_ff <= ST_DONE;
      end
      if (cmd.cell_pick) bit_ff <= cell_first;
      if (cmd.set_beyond) res_status_ff <= ST_BEYOND;
      if (cmd.set_none)   res_status_ff <= ST_NONE_FREE;
      if (cmd.write_back && command_ff == CMD_ALLOC) res_frame_ff <= ADDR_W'(full_addr);
      if (cmd.out_load) begin
         rsp_data_ff.frame_address <= res_frame_ff;
         rsp_data_ff.status        <= res_status_ff;
      end
   end

   // Control state: top summary, clear counter, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.write_back) top_ff[cur_row] <= |new_sum;
         if (cmd.clr_step)   clr_cnt_ff <= clr_cnt_ff + CELL_W'(1);
         if (cmd.out_load)   rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Status to controller
   assign stat.clr_last  = clr_cnt_ff == CELL_W'(MAP_CELLS - 1);
   assign stat.is_mark   = (command_ff == CMD_FREE) || (command_ff == CMD_USED);
   assign stat.is_alloc  = command_ff == CMD_ALLOC;
   assign stat.beyond    = beyond_ff;
   assign stat.top_empty = top_ff == '0;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== src/bfa_ctrl.sv =====
// Controller state machine: clearing pass, command sequencing, result hand-off.
// Depends on bfa_pkg; drives the datapath through bfa_cmd_type.
module bfa_ctrl
   import bfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  bfa_stat_type stat,
   output bfa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SUM,
      S_CELL,
      S_WRITE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_mark) begin
               if (stat.beyond) begin
                  cmd.set_beyond = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  cmd.mark_rd = 1'b1;
                  state_in    = S_WRITE;
               end
            end else if (stat.is_alloc) begin
               if (stat.top_empty) begin
                  cmd.set_none = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  cmd.top_pick = 1'b1;
                  state_in     = S_SUM;
               end
            end else begin
               // undefined command: plain done
               state_in = S_DONE;
            end
         end
         S_SUM: begin
            cmd.sum_pick = 1'b1;
            state_in     = S_CELL;
         end
         S_CELL: begin
            cmd.cell_pick = 1'b1;
            state_in      = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

// ===== src/bitmap_frame_allocator_core.sv =====
// Top level of the bitmap page-frame allocator (first fit).
// Depends on bfa_pkg, bfa_ctrl, bfa_dp and bitmap_frame_allocator_core_assert.svh.
//
//   Channel | Ports                              | Direction
//   --------+------------------------------------+----------
//   request | req_valid, req_stall, req_payload  | in
//   result  | rsp_valid, rsp_stall, rsp_payload  | out
//
// Each transaction steps through accept, decode, for an allocate the summary
// row read and the cell read, then write-back and result load. A mark beyond
// the map, an allocate with no free frame and an undefined command end at
// decode and go on to result load.
// After reset a clearing pass zeroes all MAP_CELLS (4096) cells of the map with
// req_stall high. A held result does not block the next request; only its
// own result waits until the output register is free.
module bitmap_frame_allocator_core
   import bfa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

`include "bitmap_frame_allocator_core_assert.svh"

   bfa_cmd_type  cmd;
   bfa_stat_type stat;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Checks
   `BFA_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), req_stall)
   `BFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `BFA_ASSERT_NOW(a_fail_zero_frame, clock, reset,
                   rsp_valid && (rsp_payload.status != ST_DONE),
                   rsp_payload.frame_address == '0)

endmodule
